// ===== design/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the stable priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned PRIO_W  = 16;
    localparam int unsigned FILL_W  = 5;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_REMOVED  = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic    load_item;
        logic    do_insert;
        logic    do_remove;
        logic    load_result;
        t_status code;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        t_op  op;
        logic full;
        logic empty;
    } t_dp_stat;

endpackage

// ===== design/spq_if.sv =====
// ----------------------------------------------------------------------------
// spq_in_if / spq_out_if
// Valid/ready channels carrying request and response items.
// ----------------------------------------------------------------------------
interface spq_in_if;
    import spq_pkg::*;

    logic                      valid;
    logic                      ready;
    t_op                       op;
    logic signed [VALUE_W-1:0] item_value;
    logic signed [PRIO_W-1:0]  item_priority;

    modport source (output valid, op, item_value, item_priority, input ready);
    modport sink   (input valid, op, item_value, item_priority, output ready);
endinterface

interface spq_out_if;
    import spq_pkg::*;

    logic                      valid;
    logic                      ready;
    t_status                   status;
    logic signed [VALUE_W-1:0] out_value;
    logic signed [PRIO_W-1:0]  out_priority;
    logic [FILL_W-1:0]         fill;

    modport source (output valid, status, out_value, out_priority, fill, input ready);
    modport sink   (input valid, status, out_value, out_priority, fill, output ready);
endinterface

// ===== design/spq_ctrl.sv =====
// ----------------------------------------------------------------------------
// spq_ctrl
// Item sequencer: capture, execute one queue operation, hold the result.
// ----------------------------------------------------------------------------
module spq_ctrl
    import spq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_cmd     o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '{load_item: 1'b0, do_insert: 1'b0, do_remove: 1'b0,
                        load_result: 1'b0, code: ST_INSERTED};
        case (r_state)
            S_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.load_item = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.load_result = 1'b1;
                if (i_stat.op == OP_INSERT) begin
                    if (i_stat.full) begin
                        o_cmd.code = ST_FULL;
                    end else begin
                        o_cmd.code      = ST_INSERTED;
                        o_cmd.do_insert = 1'b1;
                    end
                end else begin
                    if (i_stat.empty) begin
                        o_cmd.code = ST_EMPTY;
                    end else begin
                        o_cmd.code      = ST_REMOVED;
                        o_cmd.do_remove = 1'b1;
                    end
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/spq_dp.sv =====
// ----------------------------------------------------------------------------
// spq_dp
// Sorted register chain, highest priority at cell 0, with item and result
// registers. Every cell compares against the new priority in parallel.
// ----------------------------------------------------------------------------
module spq_dp
    import spq_pkg::*;
#(
    parameter int unsigned DEPTH = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cmd                      i_cmd,
    output t_dp_stat                  o_stat,
    input  t_op                       i_op,
    input  logic signed [VALUE_W-1:0] i_item_value,
    input  logic signed [PRIO_W-1:0]  i_item_priority,
    output t_status                   o_status,
    output logic signed [VALUE_W-1:0] o_out_value,
    output logic signed [PRIO_W-1:0]  o_out_priority,
    output logic [FILL_W-1:0]         o_fill
);

    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_op                       r_op;
    logic signed [VALUE_W-1:0] r_val;
    logic signed [PRIO_W-1:0]  r_prio;

    logic signed [VALUE_W-1:0] r_vals  [DEPTH];
    logic signed [PRIO_W-1:0]  r_prios [DEPTH];
    logic [CW-1:0]             r_count;
    logic [CW-1:0]             n_count;

    t_status                   r_status;
    logic signed [VALUE_W-1:0] r_out_value;
    logic signed [PRIO_W-1:0]  r_out_prio;
    logic [FILL_W-1:0]         r_fill;

    logic [DEPTH-1:0]          ge;
    logic [CW+FILL_W-1:0]      fill_ext;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_op   <= i_op;
            r_val  <= i_item_value;
            r_prio <= i_item_priority;
        end
    end

    // ge: cell is held and stays ahead of the new item
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        localparam logic [CW-1:0] IDX = CW'(gi);

        assign ge[gi] = (IDX < r_count) && (r_prios[gi] >= r_prio);

        always_ff @(posedge i_clk) begin
            if (i_cmd.do_insert) begin
                if (!ge[gi]) begin
                    if (gi == 0) begin
                        r_vals[gi]  <= r_val;
                        r_prios[gi] <= r_prio;
                    end else if (ge[(gi == 0) ? 0 : gi-1]) begin
                        r_vals[gi]  <= r_val;
                        r_prios[gi] <= r_prio;
                    end else begin
                        r_vals[gi]  <= r_vals[(gi == 0) ? 0 : gi-1];
                        r_prios[gi] <= r_prios[(gi == 0) ? 0 : gi-1];
                    end
                end
            end else if (i_cmd.do_remove) begin
                if (gi < DEPTH - 1) begin
                    r_vals[gi]  <= r_vals[(gi < DEPTH - 1) ? gi+1 : gi];
                    r_prios[gi] <= r_prios[(gi < DEPTH - 1) ? gi+1 : gi];
                end
            end
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.do_insert) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.do_remove) begin
            n_count = r_count - CW'(1);
        end
    end

    assign fill_ext = {{FILL_W{1'b0}}, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_result) begin
            r_status <= i_cmd.code;
            r_fill   <= fill_ext[FILL_W-1:0];
            if (i_cmd.do_remove) begin
                r_out_value <= r_vals[0];
                r_out_prio  <= r_prios[0];
            end else begin
                r_out_value <= '0;
                r_out_prio  <= '0;
            end
        end
    end

    assign o_stat.op    = r_op;
    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign o_stat.empty = (r_count == '0);

    assign o_status       = r_status;
    assign o_out_value    = r_out_value;
    assign o_out_priority = r_out_prio;
    assign o_fill         = r_fill;

endmodule

// ===== design/stable_priority_queue.sv =====
// ----------------------------------------------------------------------------
// stable_priority_queue
// Bounded priority queue, highest priority first, equal priorities in
// arrival order. Inserts into a full queue and removes from an empty one
// are reported by status.
//
//   channel  dir  fields
//   i_req    in   op, item_value, item_priority
//   o_rsp    out  status, out_value, out_priority, fill
//
// Each item goes through capture, one update of the sorted register chain
// (all cells compare and shift in parallel), and result presentation.
// A new item is taken only after the result has been accepted downstream.
// Reset empties the queue; entry contents are not cleared.
// ----------------------------------------------------------------------------
module stable_priority_queue
    import spq_pkg::*;
#(
    parameter int unsigned DEPTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    spq_in_if.sink     i_req,
    spq_out_if.source  o_rsp
);

    t_cmd     cmd;
    t_dp_stat stat;

    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    spq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_op            (i_req.op),
        .i_item_value    (i_req.item_value),
        .i_item_priority (i_req.item_priority),
        .o_status        (o_rsp.status),
        .o_out_value     (o_rsp.out_value),
        .o_out_priority  (o_rsp.out_priority),
        .o_fill          (o_rsp.fill)
    );

endmodule
